/* src/roc_pkg.sv */
package roc_pkg;

  localparam int unsigned IDX_W     = 32;
  localparam int unsigned GAP_W     = 32;
  localparam int unsigned CHUNK_W   = 25;
  localparam int unsigned BMIN_W    = 5;
  localparam int unsigned RCNT_W    = 2;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BYTE_W    = 56;
  localparam int unsigned SPAN_W    = 33;
  localparam int unsigned PROD_W    = SPAN_W + CHUNK_W;
  localparam int unsigned ITEMS_W   = 6;
  localparam int unsigned NEED_W    = 32;
  localparam int unsigned WASTE_W   = 64;
  localparam int unsigned IOPS_W    = 32;
  localparam int unsigned TDATA_W   = 248;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAP_LIMIT    = 2'd0,
    CFG_CHUNK_BYTES  = 2'd1,
    CFG_BATCH_MIN    = 2'd2,
    CFG_READER_COUNT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_SEGMENT = 1'b0,
    KIND_STATS   = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [IOPS_W-1:0]  io_ops_total;
    logic [WASTE_W-1:0] wasted_total;
    logic               batch_end;
    logic [NEED_W-1:0]  batch_needed_chunks;
    logic [ITEMS_W-1:0] batch_items;
    logic               reader_pass;
    logic [BYTE_W-1:0]  seg_byte_length;
    logic [BYTE_W-1:0]  seg_byte_offset;
  } out_data_t;

endpackage

/* src/read_offset_coalescer_top.sv */
// Channel  Dir  Payload                                       Accept
// s_axis   in   tdata chunk_index, tlast stream_end           tvalid & tready
// m_axis   out  tdata segment/stats fields, tuser item_kind,  tvalid & tready
//               tlast run_last
// cfg      in   cfg_addr_i register index, cfg_data_i value   cfg_valid_i & cfg_ready_o
//
// Closing a group steps through S_OFF, S_LEN, S_NEED and S_CLOSE: the one shared
// 33x25 multiplier forms offset, length and needed bytes in turn, then the update.
// A batch replay reads the batch memory in S_RD, then emits one segment per cycle
// from it in S_EMIT while m_axis is free; S_STATS emits the statistics item.
// Reset is asynchronous and needs no clearing pass. Each result waits in the output
// register while m_axis stalls, and the sequencer holds until it is taken.
module read_offset_coalescer_top #(
  parameter int unsigned MAX_BATCH_SEGS = 16,
  parameter int unsigned MAX_READERS    = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [roc_pkg::IDX_W-1:0]          s_axis_tdata_i,   // [31:0] chunk_index
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [55:0] seg_byte_offset, [111:56] seg_byte_length, [112] reader_pass,
  // [118:113] batch_items, [150:119] batch_needed_chunks, [151] batch_end,
  // [215:152] wasted_total, [247:216] io_ops_total
  output logic [roc_pkg::TDATA_W-1:0]        m_axis_tdata_o,
  output logic                               m_axis_tuser_o,   // [0] item_kind
  output logic                               m_axis_tlast_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [roc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [roc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned CntW  = $clog2(MAX_BATCH_SEGS + 1);
  localparam int unsigned IdxW  = (MAX_BATCH_SEGS > 1) ? $clog2(MAX_BATCH_SEGS) : 1;
  localparam int unsigned RepW  = $clog2(MAX_READERS + 1);
  localparam int unsigned JW    = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int unsigned ItemW = CntW + RepW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OFF   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_NEED  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_STATS = 3'd7;

  logic [2:0]                        state_q;
  logic [roc_pkg::GAP_W-1:0]         gap_q;
  logic [roc_pkg::CHUNK_W-1:0]       cb_q;
  logic [roc_pkg::BMIN_W-1:0]        bmin_q;
  logic [roc_pkg::RCNT_W-1:0]        rcnt_q;

  logic [roc_pkg::IDX_W-1:0]         first_q, latest_q, idx_q;
  logic [roc_pkg::NEED_W-1:0]        gneed_q, pneed_q;
  logic                              open_q, end_q, start_q, force_q;
  logic [CntW-1:0]                   count_q;
  logic [roc_pkg::WASTE_W-1:0]       wasted_q;
  logic [roc_pkg::IOPS_W-1:0]        iops_q;

  logic [roc_pkg::PROD_W-1:0]        prod_q, len_q;
  logic [roc_pkg::BYTE_W-1:0]        off_q;
  logic [IdxW-1:0]                   s_q;
  logic [JW-1:0]                     j_q;
  logic [RepW-1:0]                   reps_q;

  logic [roc_pkg::BYTE_W-1:0]        mem_off [MAX_BATCH_SEGS];
  logic [roc_pkg::BYTE_W-1:0]        mem_len [MAX_BATCH_SEGS];
  logic [roc_pkg::BYTE_W-1:0]        rd_off_q, rd_len_q;

  logic                              out_valid_q, out_last_q;
  roc_pkg::item_kind_e               out_kind_q;
  roc_pkg::out_data_t                out_data_q;

  logic                              out_free, in_fire, merge, out_load;
  logic [roc_pkg::IDX_W-1:0]         diff;
  logic [roc_pkg::SPAN_W-1:0]        span, mul_a;
  logic [roc_pkg::PROD_W-1:0]        mul_p;
  logic                              cnt_full, emit_now, mem_we;
  logic [CntW-1:0]                   count_new;
  logic [roc_pkg::NEED_W-1:0]        pneed_new;
  logic [2:0]                        rc_ext, reps_ext;
  logic [RepW-1:0]                   reps_d;
  logic                              seg_last, rep_last, batch_last;
  logic [IdxW-1:0]                   s_d, raddr;
  logic [ItemW-1:0]                  items_w;
  roc_pkg::out_data_t                seg_data, stats_data;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign out_load        = ((state_q == S_EMIT) || (state_q == S_STATS)) && out_free;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  assign diff  = s_axis_tdata_i - latest_q;
  assign merge = open_q && (s_axis_tdata_i >= latest_q) && (diff <= gap_q);

  assign span = {1'b0, latest_q} - {1'b0, first_q} + roc_pkg::SPAN_W'(1);

  always_comb begin
    case (state_q)
      S_OFF:   mul_a = {1'b0, first_q};
      S_LEN:   mul_a = span;
      S_NEED:  mul_a = {1'b0, gneed_q};
      default: mul_a = '0;
    endcase
  end

  assign mul_p = roc_pkg::PROD_W'(mul_a) * roc_pkg::PROD_W'(cb_q);

  assign cnt_full  = (count_q >= CntW'(MAX_BATCH_SEGS));
  assign count_new = cnt_full ? count_q : count_q + CntW'(1);
  assign pneed_new = pneed_q + gneed_q;
  assign emit_now  = force_q || (pneed_new >= roc_pkg::NEED_W'(bmin_q)) ||
                     (count_new >= CntW'(MAX_BATCH_SEGS));
  assign mem_we    = (state_q == S_CLOSE) && !cnt_full;

  assign rc_ext   = {1'b0, rcnt_q};
  assign reps_ext = (rc_ext == 3'd0) ? 3'd1 :
                    (rc_ext > 3'(MAX_READERS)) ? 3'(MAX_READERS) : rc_ext;
  assign reps_d   = RepW'(reps_ext);

  assign seg_last   = (CntW'(s_q) + CntW'(1) == count_q);
  assign rep_last   = (RepW'(j_q) + RepW'(1) == reps_q);
  assign batch_last = seg_last && rep_last;
  assign s_d        = seg_last ? '0 : s_q + IdxW'(1);
  assign raddr      = (state_q == S_EMIT && out_free) ? s_d : s_q;
  assign items_w    = ItemW'(count_q) * ItemW'(reps_q);

  always_comb begin
    seg_data                     = '0;
    seg_data.seg_byte_offset     = rd_off_q;
    seg_data.seg_byte_length     = rd_len_q;
    seg_data.reader_pass         = 1'(j_q);
    seg_data.batch_items         = roc_pkg::ITEMS_W'(items_w);
    seg_data.batch_needed_chunks = pneed_q;
    seg_data.batch_end           = batch_last;
    stats_data                   = '0;
    stats_data.wasted_total      = wasted_q;
    stats_data.io_ops_total      = iops_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_off[count_q[IdxW-1:0]] <= off_q;
      mem_len[count_q[IdxW-1:0]] <= len_q[roc_pkg::BYTE_W-1:0];
    end
    rd_off_q <= mem_off[raddr];
    rd_len_q <= mem_len[raddr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_OFF:   prod_q <= mul_p;
      S_LEN: begin
        off_q  <= prod_q[roc_pkg::BYTE_W-1:0];
        prod_q <= mul_p;
      end
      S_NEED: begin
        len_q  <= prod_q;
        prod_q <= mul_p;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= '0;
      cb_q   <= roc_pkg::CHUNK_W'(4096);
      bmin_q <= roc_pkg::BMIN_W'(1);
      rcnt_q <= roc_pkg::RCNT_W'(2);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (roc_pkg::cfg_reg_e'(cfg_addr_i))
        roc_pkg::CFG_GAP_LIMIT:    gap_q  <= cfg_data_i[roc_pkg::GAP_W-1:0];
        roc_pkg::CFG_CHUNK_BYTES:  cb_q   <= cfg_data_i[roc_pkg::CHUNK_W-1:0];
        roc_pkg::CFG_BATCH_MIN:    bmin_q <= cfg_data_i[roc_pkg::BMIN_W-1:0];
        roc_pkg::CFG_READER_COUNT: rcnt_q <= cfg_data_i[roc_pkg::RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= '0;
      latest_q    <= '0;
      gneed_q     <= '0;
      open_q      <= 1'b0;
      pneed_q     <= '0;
      count_q     <= '0;
      wasted_q    <= '0;
      iops_q      <= '0;
      idx_q       <= '0;
      end_q       <= 1'b0;
      start_q     <= 1'b0;
      force_q     <= 1'b0;
      s_q         <= '0;
      j_q         <= '0;
      reps_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_kind_q  <= roc_pkg::KIND_SEGMENT;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            end_q <= s_axis_tlast_i;
            if (merge) begin
              latest_q <= s_axis_tdata_i;
              gneed_q  <= gneed_q + roc_pkg::NEED_W'(1);
              if (s_axis_tlast_i) begin
                force_q <= 1'b1;
                state_q <= S_OFF;
              end
            end else if (open_q) begin
              idx_q   <= s_axis_tdata_i;
              start_q <= 1'b1;
              force_q <= 1'b0;
              state_q <= S_OFF;
            end else begin
              first_q  <= s_axis_tdata_i;
              latest_q <= s_axis_tdata_i;
              gneed_q  <= roc_pkg::NEED_W'(1);
              open_q   <= 1'b1;
              if (s_axis_tlast_i) begin
                force_q <= 1'b1;
                state_q <= S_OFF;
              end
            end
          end
        end
        S_OFF:  state_q <= S_LEN;
        S_LEN:  state_q <= S_NEED;
        S_NEED: state_q <= S_CLOSE;
        S_CLOSE: begin
          wasted_q <= wasted_q + roc_pkg::WASTE_W'(len_q) - roc_pkg::WASTE_W'(prod_q);
          iops_q   <= iops_q + roc_pkg::IOPS_W'(1);
          pneed_q  <= pneed_new;
          count_q  <= count_new;
          open_q   <= start_q && !emit_now && !force_q;
          if (emit_now) begin
            s_q     <= '0;
            j_q     <= '0;
            reps_q  <= reps_d;
            state_q <= S_RD;
          end else if (force_q) begin
            state_q <= S_STATS;
          end else if (start_q) begin
            first_q  <= idx_q;
            latest_q <= idx_q;
            gneed_q  <= roc_pkg::NEED_W'(1);
            start_q  <= 1'b0;
            if (end_q) begin
              force_q <= 1'b1;
              state_q <= S_OFF;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_RD: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_kind_q <= roc_pkg::KIND_SEGMENT;
            out_last_q <= batch_last && !end_q;
            out_data_q <= seg_data;
            s_q        <= s_d;
            if (seg_last) begin
              j_q <= j_q + JW'(1);
            end
            if (batch_last) begin
              count_q <= '0;
              pneed_q <= '0;
              if (force_q) begin
                state_q <= S_STATS;
              end else if (start_q) begin
                first_q  <= idx_q;
                latest_q <= idx_q;
                gneed_q  <= roc_pkg::NEED_W'(1);
                open_q   <= 1'b1;
                start_q  <= 1'b0;
                if (end_q) begin
                  force_q <= 1'b1;
                  state_q <= S_OFF;
                end else begin
                  state_q <= S_IDLE;
                end
              end else begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        S_STATS: begin
          if (out_free) begin
            out_kind_q <= roc_pkg::KIND_STATS;
            out_last_q <= 1'b1;
            out_data_q <= stats_data;
            first_q    <= '0;
            latest_q   <= '0;
            gneed_q    <= '0;
            open_q     <= 1'b0;
            pneed_q    <= '0;
            count_q    <= '0;
            wasted_q   <= '0;
            iops_q     <= '0;
            force_q    <= 1'b0;
            end_q      <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_BATCH_SEGS))
    else $error("batch count above buffer depth");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT || state_q == S_RD) |-> (count_q != '0))
    else $error("replay of an empty batch");

  a_group_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (first_q <= latest_q))
    else $error("group start above group end");

  a_stats_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == roc_pkg::KIND_STATS) |-> out_last_q)
    else $error("statistics item not marked last");

  a_stats_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STATS && out_free) |=> (state_q == S_IDLE && !open_q && count_q == '0))
    else $error("stream state not cleared after statistics");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int BATCH_SEGS  = 16;
  localparam int READERS     = 2;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [roc_pkg::IDX_W-1:0] idx;
    logic                      last;
  } chunk_req_t;

  typedef struct {
    roc_pkg::item_kind_e kind;
    roc_pkg::out_data_t  data;
    logic                last;
  } read_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_valid = 1'b0;
  logic [roc_pkg::IDX_W-1:0]      s_data = '0;
  logic                           s_last = 1'b0;
  logic                           m_ready = 1'b0;
  logic                           cfg_valid = 1'b0;
  logic [roc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [roc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tready_o;
  logic                           m_axis_tvalid_o;
  logic [roc_pkg::TDATA_W-1:0]    m_axis_tdata_o;
  logic                           m_axis_tuser_o;
  logic                           m_axis_tlast_o;
  logic                           cfg_ready_o;

  read_offset_coalescer_top #(
    .MAX_BATCH_SEGS(BATCH_SEGS),
    .MAX_READERS   (READERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  logic [roc_pkg::GAP_W-1:0]   cfg_gap = '0;
  logic [roc_pkg::CHUNK_W-1:0] cfg_chunk = 25'd4096;
  logic [roc_pkg::BMIN_W-1:0]  cfg_bmin = 5'd1;
  logic [roc_pkg::RCNT_W-1:0]  cfg_readers = 2'd2;

  logic [roc_pkg::IDX_W-1:0]   grp_first = '0;
  logic [roc_pkg::IDX_W-1:0]   grp_latest = '0;
  logic [roc_pkg::NEED_W-1:0]  grp_needed = '0;
  bit                          grp_open = 1'b0;
  logic [roc_pkg::NEED_W-1:0]  batch_needed = '0;
  int                          batch_cnt = 0;
  logic [roc_pkg::BYTE_W-1:0]  pend_off [BATCH_SEGS];
  logic [roc_pkg::BYTE_W-1:0]  pend_len [BATCH_SEGS];
  logic [roc_pkg::WASTE_W-1:0] wasted_sum = '0;
  logic [roc_pkg::IOPS_W-1:0]  io_ops_sum = '0;

  read_result_t step_results[$];
  read_result_t read_results_q[$];
  chunk_req_t   chunk_req_q[$];

  int          in_taken = 0;
  int          in_sent = 0;
  int          in_gap = 0;
  bit          in_burst = 1'b0;
  int          out_taken = 0;
  int          out_seen = 0;
  int          rx_wait = 0;
  bit          rx_burst = 1'b0;
  logic        rx_hold = 1'b0;
  bit          hold_go = 1'b0;
  int          mismatches = 0;
  int          n_segments = 0;
  int          n_stats = 0;
  int          n_requests = 0;
  int          n_cfg_writes = 0;
  int unsigned cycle_cnt = 0;

  task emit_batch();
    int reps;
    int items_v;
    read_result_t r;
    reps = (cfg_readers == 0) ? 1 : ((int'(cfg_readers) > READERS) ? READERS : cfg_readers);
    items_v = batch_cnt * reps;
    for (int j = 0; j < reps; j++) begin
      for (int s = 0; s < batch_cnt; s++) begin
        r.kind = roc_pkg::KIND_SEGMENT;
        r.data = '0;
        r.data.seg_byte_offset = pend_off[s];
        r.data.seg_byte_length = pend_len[s];
        r.data.reader_pass = j[0];
        r.data.batch_items = items_v[roc_pkg::ITEMS_W-1:0];
        r.data.batch_needed_chunks = batch_needed;
        r.data.batch_end = (j == reps - 1) && (s == batch_cnt - 1);
        r.last = 1'b0;
        step_results.insert(step_results.size(), r);
      end
    end
    batch_cnt = 0;
    batch_needed = '0;
  endtask

  task close_group(input bit force_emit);
    logic [63:0] span;
    logic [63:0] len;
    logic [63:0] need;
    logic [63:0] off;
    span = {32'd0, grp_latest} - {32'd0, grp_first} + 64'd1;
    len = span * {39'd0, cfg_chunk};
    need = {32'd0, grp_needed} * {39'd0, cfg_chunk};
    off = {32'd0, grp_first} * {39'd0, cfg_chunk};
    if (batch_cnt < BATCH_SEGS) begin
      pend_off[batch_cnt] = off[roc_pkg::BYTE_W-1:0];
      pend_len[batch_cnt] = len[roc_pkg::BYTE_W-1:0];
      batch_cnt++;
    end
    wasted_sum = wasted_sum + (len - need);
    io_ops_sum = io_ops_sum + 1;
    batch_needed = batch_needed + grp_needed;
    grp_open = 1'b0;
    if (force_emit || batch_needed >= {27'd0, cfg_bmin} || batch_cnt >= BATCH_SEGS)
      emit_batch();
  endtask

  task coalesce_index(input logic [roc_pkg::IDX_W-1:0] idx, input logic stream_end);
    read_result_t r;
    step_results.delete();
    if (grp_open && idx >= grp_latest && (idx - grp_latest) <= cfg_gap) begin
      grp_latest = idx;
      grp_needed = grp_needed + 1;
    end else begin
      if (grp_open) close_group(1'b0);
      grp_first = idx;
      grp_latest = idx;
      grp_needed = 1;
      grp_open = 1'b1;
    end
    if (stream_end) begin
      close_group(1'b1);
      r.kind = roc_pkg::KIND_STATS;
      r.data = '0;
      r.data.wasted_total = wasted_sum;
      r.data.io_ops_total = io_ops_sum;
      r.last = 1'b0;
      step_results.insert(step_results.size(), r);
      grp_first = '0;
      grp_latest = '0;
      grp_needed = '0;
      grp_open = 1'b0;
      batch_cnt = 0;
      batch_needed = '0;
      wasted_sum = '0;
      io_ops_sum = '0;
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) read_results_q.insert(read_results_q.size(), step_results[i]);
  endtask

  task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %0s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin : drive_chunks
    logic nv;
    chunk_req_t r;
    if (rst_ni) begin
      nv = s_valid;
      if (s_valid && in_taken == in_sent) begin
        nv = 1'b0;
        in_gap = in_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (chunk_req_q.size() > 0) begin
          r = chunk_req_q.pop_front();
          s_data <= r.idx;
          s_last <= r.last;
          nv = 1'b1;
          in_sent++;
        end
      end
      s_valid <= nv;
    end
  end

  always @(negedge clk_i) begin : drive_ready
    logic nr;
    if (rst_ni) begin
      if (out_taken != out_seen) begin
        out_seen = out_taken;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      end
      if (rx_hold) begin
        nr = 1'b0;
      end else if (rx_wait > 0) begin
        nr = 1'b0;
        rx_wait--;
      end else begin
        nr = 1'b1;
      end
      m_ready <= nr;
    end
  end

  initial begin : hold_output
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : watch_streams
    read_result_t want;
    roc_pkg::out_data_t got;
    if (rst_ni) begin
      if (s_valid && s_axis_tready_o) begin
        coalesce_index(s_data, s_last);
        in_taken++;
      end
      if (m_axis_tvalid_o && m_ready) begin
        out_taken++;
        got = m_axis_tdata_o;
        if (read_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result: kind %0d tdata %h", $time, m_axis_tuser_o, got);
        end else begin
          want = read_results_q.pop_front();
          if (want.kind == roc_pkg::KIND_STATS) n_stats++;
          else n_segments++;
          check_field("item_kind", want.kind, m_axis_tuser_o);
          check_field("seg_byte_offset", want.data.seg_byte_offset, got.seg_byte_offset);
          check_field("seg_byte_length", want.data.seg_byte_length, got.seg_byte_length);
          check_field("reader_pass", want.data.reader_pass, got.reader_pass);
          check_field("batch_items", want.data.batch_items, got.batch_items);
          check_field("batch_needed_chunks", want.data.batch_needed_chunks,
                      got.batch_needed_chunks);
          check_field("batch_end", want.data.batch_end, got.batch_end);
          check_field("wasted_total", want.data.wasted_total, got.wasted_total);
          check_field("io_ops_total", want.data.io_ops_total, got.io_ops_total);
          check_field("run_last", want.last, m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               read_results_q.size());
      $display("[read_offset_coalescer_top] ERROR");
      $finish;
    end
  end

  task write_reg(input roc_pkg::cfg_reg_e r, input logic [roc_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (r)
      roc_pkg::CFG_GAP_LIMIT:    cfg_gap = v;
      roc_pkg::CFG_CHUNK_BYTES:  cfg_chunk = v[roc_pkg::CHUNK_W-1:0];
      roc_pkg::CFG_BATCH_MIN:    cfg_bmin = v[roc_pkg::BMIN_W-1:0];
      roc_pkg::CFG_READER_COUNT: cfg_readers = v[roc_pkg::RCNT_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task set_config(input logic [31:0] gap, input logic [31:0] chunk, input logic [31:0] bmin,
                  input logic [31:0] readers);
    write_reg(roc_pkg::CFG_GAP_LIMIT, gap);
    write_reg(roc_pkg::CFG_CHUNK_BYTES, chunk);
    write_reg(roc_pkg::CFG_BATCH_MIN, bmin);
    write_reg(roc_pkg::CFG_READER_COUNT, readers);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task random_config();
    logic [31:0] gap;
    logic [31:0] chunk;
    case ($urandom_range(0, 4))
      0: gap = 0;
      1: gap = $urandom_range(1, 4);
      2: gap = $urandom_range(5, 100);
      3: gap = $urandom;
      default: gap = 32'hFFFF_FFFF;
    endcase
    case ($urandom_range(0, 3))
      0: chunk = 1;
      1: chunk = 32'd16777216;
      2: chunk = $urandom_range(1, 16777216);
      default: chunk = 32'd1 << $urandom_range(0, 24);
    endcase
    set_config(gap, chunk, $urandom_range(0, 31), $urandom_range(0, 3));
  endtask

  task queue_chunk(input logic [roc_pkg::IDX_W-1:0] idx, input logic last);
    chunk_req_t r;
    r.idx = idx;
    r.last = last;
    chunk_req_q.insert(chunk_req_q.size(), r);
    n_requests++;
  endtask

  task queue_streams(input int n);
    logic [roc_pkg::IDX_W-1:0] cur;
    int left;
    int sel;
    left = 0;
    for (int i = 0; i < n; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 30);
        cur = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 64);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 6) cur = cur + $urandom_range(0, 4);
        else if (sel < 8) cur = cur + cfg_gap + (sel - 6);
        else if (sel == 8) cur = $urandom;
        else cur = cur - $urandom_range(1, 8);
      end
      left--;
      queue_chunk(cur, left == 0 || i == n - 1);
    end
  endtask

  task wait_idle();
    @(posedge clk_i);
    while (chunk_req_q.size() != 0 || s_valid || read_results_q.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_chunk(32'd0, 1'b0);
    queue_chunk(32'd0, 1'b0);
    queue_chunk(32'd1, 1'b0);
    queue_chunk(32'hFFFF_FFFF, 1'b0);
    queue_chunk(32'd5, 1'b0);
    queue_chunk(32'd5, 1'b1);
    wait_idle();

    set_config(32'hFFFF_FFFF, 32'd16777216, 32'd0, 32'd0);
    queue_chunk(32'd0, 1'b0);
    queue_chunk(32'hFFFF_FFFF, 1'b0);
    queue_chunk(32'd3, 1'b1);
    wait_idle();

    set_config(32'd3, 32'd1, 32'd31, 32'd3);
    for (int k = 0; k <= 16; k++) queue_chunk(k * 10, k == 16);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_config(32'hFFFF_FFFF, 32'd16777216, 32'd16, 32'd2);
        1: set_config(32'd0, 32'd1, 32'd1, 32'd1);
        default: random_config();
      endcase
      queue_streams(43);
      if (p == 2) hold_go = 1'b1;
      wait_idle();
    end

    $display("covered %0d chunk requests over %0d streams and %0d register writes",
             n_requests, n_stats, n_cfg_writes);
    $display("checked %0d segment results and %0d statistics results, %0d mismatches",
             n_segments, n_stats, mismatches);
    if (mismatches == 0 && read_results_q.size() == 0)
      $display("[read_offset_coalescer_top] OK");
    else
      $display("[read_offset_coalescer_top] ERROR");
    $finish;
  end

endmodule
